@@ hw/rtl/swe_pkg.sv @@
// Shared types and constants of the sliding min/max envelope block.
package swe_pkg;

  // Sample index and output position width.
  localparam int unsigned IDX_BITS = 16;
  // Radius register width and reset value.
  localparam int unsigned RAD_BITS = 5;
  localparam logic [RAD_BITS-1:0] RAD_RESET = 5'd8;
  // Width of clipped radius, result count, result counter and lag.
  localparam int unsigned RW = 6;
  // Width of the expiry age limit (lag + radius).
  localparam int unsigned LIM_BITS = 7;
  // Saturation point of the per-series sample count.
  localparam logic [RW-1:0] WARM_MAX = 6'd63;

  // Deque commands issued by the sequencer.
  typedef enum logic [2:0] {
    DQ_NOP,
    DQ_RD_TAIL,
    DQ_RD_HEAD,
    DQ_POP_TAIL,
    DQ_POP_HEAD,
    DQ_PUSH,
    DQ_CLEAR
  } dq_op_e;

  // Deque occupancy status seen by the sequencer.
  typedef struct packed {
    logic empty;
    logic multi;
  } dq_stat_t;

endpackage

@@ hw/rtl/swe_if.sv @@
// Handshake channel interfaces: sample input, envelope output, radius write.
interface swe_in_if #(
  parameter int unsigned SW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample;
  logic                 last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swe_out_if #(
  parameter int unsigned SW = 16
);
  logic                               valid;
  logic                               ready;
  logic signed [SW-1:0]               upper;
  logic signed [SW-1:0]               lower;
  logic [swe_pkg::IDX_BITS-1:0]       position;
  logic                               last_point;

  modport source (output valid, output upper, output lower, output position,
                  output last_point, input ready);
  modport sink   (input valid, input upper, input lower, input position,
                  input last_point, output ready);
endinterface

interface swe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [swe_pkg::RAD_BITS-1:0] radius;

  modport source (output valid, output radius, input ready);
  modport sink   (input valid, input radius, output ready);
endinterface

@@ hw/rtl/swe_deque.sv @@
// Circular deque of (index, value) entries in a one-write one-read memory.
module swe_deque #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned VW    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  swe_pkg::dq_op_e              op_i,
  input  logic [swe_pkg::IDX_BITS-1:0] wr_idx_i,
  input  logic signed [VW-1:0]         wr_val_i,
  output swe_pkg::dq_stat_t            stat_o,
  output logic [swe_pkg::IDX_BITS-1:0] rd_idx_o,
  output logic signed [VW-1:0]         rd_val_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  logic [swe_pkg::IDX_BITS-1:0] idx_mem_q [DEPTH];
  logic signed [VW-1:0]         val_mem_q [DEPTH];

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] raddr, waddr, tail_addr, head_inc;
  logic [CW-1:0] head_plus_cnt;
  logic          full;

  function automatic logic [AW-1:0] wrap_idx(input logic [CW-1:0] x);
    logic [CW-1:0] y;
    y = (x >= CW'(DEPTH)) ? x - CW'(DEPTH) : x;
    return y[AW-1:0];
  endfunction

  assign head_plus_cnt = {1'b0, head_q} + count_q;
  assign tail_addr     = wrap_idx(head_plus_cnt - CW'(1));
  assign head_inc      = wrap_idx({1'b0, head_q} + CW'(1));
  // When full the oldest entry is dropped and its slot reused.
  assign waddr         = wrap_idx(head_plus_cnt);
  assign full          = (count_q == CW'(DEPTH));
  assign raddr         = (op_i == swe_pkg::DQ_RD_TAIL) ? tail_addr : head_q;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    case (op_i)
      swe_pkg::DQ_POP_TAIL: begin
        count_d = count_q - CW'(1);
      end
      swe_pkg::DQ_POP_HEAD: begin
        head_d  = head_inc;
        count_d = count_q - CW'(1);
      end
      swe_pkg::DQ_PUSH: begin
        if (full) begin
          head_d = head_inc;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      swe_pkg::DQ_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == swe_pkg::DQ_PUSH) begin
      idx_mem_q[waddr] <= wr_idx_i;
      val_mem_q[waddr] <= wr_val_i;
    end
    rd_idx_o <= idx_mem_q[raddr];
    rd_val_o <= val_mem_q[raddr];
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.multi = (count_q > CW'(1));

endmodule

@@ hw/rtl/swe_cmp.sv @@
// Shared compare unit: back-pop test on values and front-expiry test on ages.
module swe_cmp #(
  parameter int unsigned VW = 16
) (
  input  logic                         keep_max_i,
  input  logic signed [VW-1:0]         stored_i,
  input  logic signed [VW-1:0]         incoming_i,
  input  logic [swe_pkg::IDX_BITS-1:0] now_i,
  input  logic [swe_pkg::IDX_BITS-1:0] entry_idx_i,
  input  logic [swe_pkg::LIM_BITS-1:0] limit_i,
  output logic                         drop_tail_o,
  output logic                         too_old_o
);

  logic [swe_pkg::IDX_BITS-1:0] age;

  // Newer equal values replace older ones.
  assign drop_tail_o = keep_max_i ? (stored_i <= incoming_i) : (stored_i >= incoming_i);

  // Modular age, correct across index wrap.
  assign age       = now_i - entry_idx_i;
  assign too_old_o = (age > swe_pkg::IDX_BITS'(limit_i));

endmodule

@@ hw/rtl/sliding_min_max_envelope.sv @@
// Top level: sequencer driving two deques through a shared compare unit.
//
//  channel  dir  handshake        payload
//  samp_i   in   valid / ready    sample, last_sample
//  env_o    out  valid / ready    upper, lower, position, last_point
//  cfg_i    in   valid / ready    radius (ready always high)
//
// A sample goes through the upper then the lower deque: the tail is read,
// entries it dominates are popped from the back, then it is pushed; each
// envelope point it releases pops expired front entries and reads both heads.
// Rate is set by the single compare unit, used serially for the upper then
// the lower deque, and by the one read port of each deque memory.
// Reset leaves both deques empty, radius 8; no clearing pass is needed.
// samp_i is ready only between samples; a full env_o register stalls the
// sequencer only when the next point is ready to be written.
module sliding_min_max_envelope #(
  parameter int unsigned R_MAX       = 31,
  parameter int unsigned DEQUE_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swe_in_if.sink    samp_i,
  swe_out_if.source env_o,
  swe_cfg_if.sink   cfg_i
);

  localparam int unsigned RW = swe_pkg::RW;
  localparam int unsigned IW = swe_pkg::IDX_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_CHK,
    ST_POP_CMP,
    ST_PUSH,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_EMIT,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [swe_pkg::RAD_BITS-1:0] radius_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          last_q;
  logic [RW-1:0]                 r_q, seen_q, n_q, k_q;
  logic [IW-1:0]                 idx_q;
  logic                          sel_lo_q;
  logic signed [SAMPLE_BITS-1:0] env_hi_q, env_lo_q;

  logic signed [SAMPLE_BITS-1:0] out_upper_q, out_lower_q;
  logic [IW-1:0]                 out_pos_q;
  logic                          out_last_q, out_valid_q;

  logic [RW-1:0]                 r_clip, n_calc, back, k_next;
  logic [swe_pkg::LIM_BITS-1:0]  limit;
  logic                          out_free, final_pt;

  swe_pkg::dq_op_e               op, up_op, lo_op;
  swe_pkg::dq_stat_t             up_stat, lo_stat, sel_stat;
  logic [IW-1:0]                 up_idx, lo_idx, sel_idx;
  logic signed [SAMPLE_BITS-1:0] up_val, lo_val, sel_val;
  logic                          drop_tail, too_old;

  swe_deque #(.DEPTH(DEQUE_DEPTH), .VW(SAMPLE_BITS)) u_dq_upper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (up_op),
    .wr_idx_i (idx_q),
    .wr_val_i (sample_q),
    .stat_o   (up_stat),
    .rd_idx_o (up_idx),
    .rd_val_o (up_val)
  );

  swe_deque #(.DEPTH(DEQUE_DEPTH), .VW(SAMPLE_BITS)) u_dq_lower (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (lo_op),
    .wr_idx_i (idx_q),
    .wr_val_i (sample_q),
    .stat_o   (lo_stat),
    .rd_idx_o (lo_idx),
    .rd_val_o (lo_val)
  );

  assign sel_stat = sel_lo_q ? lo_stat : up_stat;
  assign sel_idx  = sel_lo_q ? lo_idx  : up_idx;
  assign sel_val  = sel_lo_q ? lo_val  : up_val;

  swe_cmp #(.VW(SAMPLE_BITS)) u_cmp (
    .keep_max_i  (!sel_lo_q),
    .stored_i    (sel_val),
    .incoming_i  (sample_q),
    .now_i       (idx_q),
    .entry_idx_i (sel_idx),
    .limit_i     (limit),
    .drop_tail_o (drop_tail),
    .too_old_o   (too_old)
  );

  assign r_clip = ({1'b0, radius_q} > RW'(R_MAX)) ? RW'(R_MAX) : {1'b0, radius_q};

  // Points released by this sample: one once warmed up, all pending at the end.
  assign n_calc = last_q ? ((seen_q < r_q + RW'(1)) ? seen_q : r_q + RW'(1))
                         : ((seen_q > r_q) ? RW'(1) : RW'(0));

  assign back     = last_q ? (n_q - RW'(1) - k_q) : r_q;
  assign limit    = {1'b0, back} + {1'b0, r_q};
  assign k_next   = k_q + RW'(1);
  assign final_pt = (k_next == n_q);
  assign out_free = !out_valid_q || env_o.ready;

  always_comb begin
    op = swe_pkg::DQ_NOP;
    case (state_q)
      ST_PUSH_CHK: begin
        if (!sel_stat.empty) begin
          op = swe_pkg::DQ_RD_TAIL;
        end
      end
      ST_POP_CMP: begin
        if (drop_tail) begin
          op = swe_pkg::DQ_POP_TAIL;
        end
      end
      ST_PUSH:    op = swe_pkg::DQ_PUSH;
      ST_EXP_RD:  op = swe_pkg::DQ_RD_HEAD;
      ST_EXP_CMP: begin
        if (sel_stat.multi && too_old) begin
          op = swe_pkg::DQ_POP_HEAD;
        end
      end
      default: begin
      end
    endcase
    up_op = sel_lo_q ? swe_pkg::DQ_NOP : op;
    lo_op = sel_lo_q ? op : swe_pkg::DQ_NOP;
    // Series end empties both deques together.
    if (state_q == ST_FINISH && last_q) begin
      up_op = swe_pkg::DQ_CLEAR;
      lo_op = swe_pkg::DQ_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= swe_pkg::RAD_RESET;
    end else if (cfg_i.valid) begin
      radius_q <= cfg_i.radius;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      idx_q       <= '0;
      sel_lo_q    <= 1'b0;
      k_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In ST_EMIT the output register is either refilled or still held.
      if (out_valid_q && env_o.ready && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (samp_i.valid) begin
            sample_q <= samp_i.sample;
            last_q   <= samp_i.last_sample;
            r_q      <= r_clip;
            if (seen_q < swe_pkg::WARM_MAX) begin
              seen_q <= seen_q + RW'(1);
            end
            sel_lo_q <= 1'b0;
            state_q  <= ST_PUSH_CHK;
          end
        end
        ST_PUSH_CHK: begin
          state_q <= sel_stat.empty ? ST_PUSH : ST_POP_CMP;
        end
        ST_POP_CMP: begin
          state_q <= drop_tail ? ST_PUSH_CHK : ST_PUSH;
        end
        ST_PUSH: begin
          if (!sel_lo_q) begin
            sel_lo_q <= 1'b1;
            state_q  <= ST_PUSH_CHK;
          end else begin
            n_q      <= n_calc;
            k_q      <= '0;
            sel_lo_q <= 1'b0;
            state_q  <= (n_calc == '0) ? ST_FINISH : ST_EXP_RD;
          end
        end
        ST_EXP_RD: begin
          state_q <= ST_EXP_CMP;
        end
        ST_EXP_CMP: begin
          if (sel_stat.multi && too_old) begin
            state_q <= ST_EXP_RD;
          end else if (!sel_lo_q) begin
            env_hi_q <= sel_val;
            sel_lo_q <= 1'b1;
            state_q  <= ST_EXP_RD;
          end else begin
            env_lo_q <= sel_val;
            state_q  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_upper_q <= env_hi_q;
            out_lower_q <= env_lo_q;
            out_pos_q   <= idx_q - IW'(back);
            out_last_q  <= last_q && final_pt;
            k_q         <= k_next;
            sel_lo_q    <= 1'b0;
            state_q     <= final_pt ? ST_FINISH : ST_EXP_RD;
          end
        end
        ST_FINISH: begin
          if (last_q) begin
            idx_q  <= '0;
            seen_q <= '0;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign samp_i.ready     = (state_q == ST_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign env_o.valid      = out_valid_q;
  assign env_o.upper      = out_upper_q;
  assign env_o.lower      = out_lower_q;
  assign env_o.position   = out_pos_q;
  assign env_o.last_point = out_last_q;

endmodule
